// ----- rtl/pidc_pkg.sv -----
// Shared types, widths and constants of the clamped PID controller.
`timescale 1ns / 1ps

package pidc_pkg;

    // Default width of the integral accumulator (LSB 2^-22).
    localparam int INTEGRAL_WIDTH_DEF = 40;

    // Fixed field widths.
    localparam int GAIN_W   = 16;   // Q8.8 gains
    localparam int ANGLE_W  = 16;   // Q10.6 angles
    localparam int DRIVE_W  = 8;    // integer drive value
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths.
    localparam int ERR_W    = 17;   // Q11.6 error, always exact
    localparam int DIFF_W   = 18;   // error minus previous error
    localparam int DERIV_W  = 23;   // difference times 25
    localparam int INC_W    = 30;   // error times the Q.16 sample period
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 33;
    localparam int PROD_W   = 50;
    localparam int ACC_W    = 64;   // Q.30 sum of all three terms
    localparam int IACC_W   = 81;   // exact integral term before saturation
    localparam int ISAT_W   = 62;   // integral term after saturation
    localparam int INT_EXT_W = 64;  // integral split into two 32-bit halves
    localparam int RND_W    = 34;   // rounded magnitude
    localparam int GAIN_SHIFT = 16; // Q.14 products up to Q.30
    localparam int HALF_SHIFT = 32; // weight of the upper integral half
    localparam int TERM_LIMIT_SHIFT = 60;
    localparam int ROUND_SHIFT = 30;

    // Sample period 0.04 in Q.16.
    localparam int DT_Q16 = 2621;

    // Reset values of the drive limits.
    localparam logic [DRIVE_W-1:0] OUTPUT_MIN_RST = 8'd0;
    localparam logic [DRIVE_W-1:0] OUTPUT_MAX_RST = 8'd180;

    // Input command codes (carried in tuser).
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_TARGET_ANGLE = 3'd3,
        REG_OUTPUT_MIN   = 3'd4,
        REG_OUTPUT_MAX   = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        MUL_ERR_DT,
        MUL_PROP,
        MUL_DERIV,
        MUL_INT_LO,
        MUL_INT_HI
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_INC,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_ILO,
        ST_MUL_IHI,
        ST_I_ADD,
        ST_SUM,
        ST_ROUND,
        ST_CLAMP
    } state_t;

    typedef struct packed {
        logic     load_err;
        logic     clear;
        mul_sel_t mul_sel;
        logic     deriv_upd;
        logic     int_upd;
        logic     p_load;
        logic     d_add;
        logic     ilo_load;
        logic     ihi_add;
        logic     sum_load;
        logic     round_load;
        logic     out_load;
    } dp_cmd_t;

endpackage

// ----- rtl/pidc_ctrl.sv -----
// Sequencer of the PID step: input/output handshake and datapath commands.
`timescale 1ns / 1ps

module pidc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_cmd,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output pidc_pkg::dp_cmd_t  cmd
);

    pidc_pkg::state_t state_reg;
    pidc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             out_free;

    assign in_ready  = (state_reg == pidc_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pidc_pkg::ST_IDLE:
            begin
                if (accept && (in_cmd == pidc_pkg::CMD_SAMPLE))
                begin
                    state_next = pidc_pkg::ST_MUL_INC;
                end
            end
            pidc_pkg::ST_MUL_INC: state_next = pidc_pkg::ST_MUL_P;
            pidc_pkg::ST_MUL_P:   state_next = pidc_pkg::ST_MUL_D;
            pidc_pkg::ST_MUL_D:   state_next = pidc_pkg::ST_MUL_ILO;
            pidc_pkg::ST_MUL_ILO: state_next = pidc_pkg::ST_MUL_IHI;
            pidc_pkg::ST_MUL_IHI: state_next = pidc_pkg::ST_I_ADD;
            pidc_pkg::ST_I_ADD:   state_next = pidc_pkg::ST_SUM;
            pidc_pkg::ST_SUM:     state_next = pidc_pkg::ST_ROUND;
            pidc_pkg::ST_ROUND:   state_next = pidc_pkg::ST_CLAMP;
            pidc_pkg::ST_CLAMP:
            begin
                if (out_free)
                begin
                    state_next = pidc_pkg::ST_IDLE;
                end
            end
            default: state_next = pidc_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = pidc_pkg::MUL_ERR_DT;
        case (state_reg)
            pidc_pkg::ST_IDLE:
            begin
                cmd.load_err = accept && (in_cmd == pidc_pkg::CMD_SAMPLE);
                cmd.clear    = accept && (in_cmd == pidc_pkg::CMD_CLEAR);
            end
            pidc_pkg::ST_MUL_INC:
            begin
                cmd.mul_sel   = pidc_pkg::MUL_ERR_DT;
                cmd.deriv_upd = 1'b1;
            end
            pidc_pkg::ST_MUL_P:
            begin
                cmd.mul_sel = pidc_pkg::MUL_PROP;
                cmd.int_upd = 1'b1;
            end
            pidc_pkg::ST_MUL_D:
            begin
                cmd.mul_sel = pidc_pkg::MUL_DERIV;
                cmd.p_load  = 1'b1;
            end
            pidc_pkg::ST_MUL_ILO:
            begin
                cmd.mul_sel = pidc_pkg::MUL_INT_LO;
                cmd.d_add   = 1'b1;
            end
            pidc_pkg::ST_MUL_IHI:
            begin
                cmd.mul_sel  = pidc_pkg::MUL_INT_HI;
                cmd.ilo_load = 1'b1;
            end
            pidc_pkg::ST_I_ADD:  cmd.ihi_add    = 1'b1;
            pidc_pkg::ST_SUM:    cmd.sum_load   = 1'b1;
            pidc_pkg::ST_ROUND:  cmd.round_load = 1'b1;
            pidc_pkg::ST_CLAMP:  cmd.out_load   = out_free;
            default:             cmd            = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// ----- rtl/pidc_datapath.sv -----
// Datapath of the PID step: settings, state, shared multiplier, round and clamp.
`timescale 1ns / 1ps

module pidc_datapath #(
    parameter int INTEGRAL_WIDTH = pidc_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [pidc_pkg::ANGLE_W-1:0]  meas_angle,
    input  pidc_pkg::dp_cmd_t                    cmd,
    output logic [pidc_pkg::DRIVE_W-1:0]         drive
);

    localparam int ERR_W    = pidc_pkg::ERR_W;
    localparam int DIFF_W   = pidc_pkg::DIFF_W;
    localparam int DERIV_W  = pidc_pkg::DERIV_W;
    localparam int INC_W    = pidc_pkg::INC_W;
    localparam int MUL_A_W  = pidc_pkg::MUL_A_W;
    localparam int MUL_B_W  = pidc_pkg::MUL_B_W;
    localparam int PROD_W   = pidc_pkg::PROD_W;
    localparam int ACC_W    = pidc_pkg::ACC_W;
    localparam int IACC_W   = pidc_pkg::IACC_W;
    localparam int ISAT_W   = pidc_pkg::ISAT_W;
    localparam int EXT_W    = pidc_pkg::INT_EXT_W;
    localparam int RND_W    = pidc_pkg::RND_W;
    localparam int DRIVE_W  = pidc_pkg::DRIVE_W;
    localparam int HALF_W   = EXT_W / 2;
    localparam int ISUM_W   = ((INTEGRAL_WIDTH > INC_W) ? INTEGRAL_WIDTH : INC_W) + 1;

    localparam logic signed [ISUM_W-1:0] IMAX =
        {{(ISUM_W - INTEGRAL_WIDTH + 1){1'b0}}, {(INTEGRAL_WIDTH - 1){1'b1}}};
    localparam logic signed [ISUM_W-1:0] IMIN =
        {{(ISUM_W - INTEGRAL_WIDTH + 1){1'b1}}, {(INTEGRAL_WIDTH - 1){1'b0}}};
    localparam logic signed [IACC_W-1:0] LIM_POS =
        IACC_W'(1) <<< pidc_pkg::TERM_LIMIT_SHIFT;
    localparam logic signed [IACC_W-1:0] LIM_NEG = -LIM_POS;
    localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (pidc_pkg::ROUND_SHIFT - 1);

    // Settings
    logic signed [pidc_pkg::GAIN_W-1:0]  prop_gain_reg;
    logic signed [pidc_pkg::GAIN_W-1:0]  integ_gain_reg;
    logic signed [pidc_pkg::GAIN_W-1:0]  deriv_gain_reg;
    logic signed [pidc_pkg::ANGLE_W-1:0] target_angle_reg;
    logic [DRIVE_W-1:0]                  output_min_reg;
    logic [DRIVE_W-1:0]                  output_max_reg;

    // Controller state and working registers
    logic signed [INTEGRAL_WIDTH-1:0] integ_reg;
    logic signed [INTEGRAL_WIDTH-1:0] integ_next;
    logic signed [ERR_W-1:0]          last_error_reg;
    logic signed [ERR_W-1:0]          err_reg;
    logic signed [DERIV_W-1:0]        deriv_reg;
    logic signed [PROD_W-1:0]         prod_reg;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [IACC_W-1:0]         iacc_reg;
    logic signed [ACC_W-1:0]          sum_reg;
    logic [RND_W-1:0]                 rnd_reg;
    logic                             neg_reg;
    logic [DRIVE_W-1:0]               drive_reg;

    logic signed [ERR_W-1:0]   err_calc;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DERIV_W-1:0] diff_ext;
    logic signed [DERIV_W-1:0] deriv_calc;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_full;
    logic signed [EXT_W-1:0]   integ_ext;
    logic signed [INC_W-1:0]   inc;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [ISAT_W-1:0]  isat;
    logic [ACC_W-1:0]          rnd_sum;
    logic [DRIVE_W-1:0]        drive_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            target_angle_reg <= '0;
            output_min_reg   <= pidc_pkg::OUTPUT_MIN_RST;
            output_max_reg   <= pidc_pkg::OUTPUT_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (pidc_pkg::cfg_index_t'(cfg_index))
                pidc_pkg::REG_PROP_GAIN:    prop_gain_reg    <= cfg_data;
                pidc_pkg::REG_INTEG_GAIN:   integ_gain_reg   <= cfg_data;
                pidc_pkg::REG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data;
                pidc_pkg::REG_TARGET_ANGLE: target_angle_reg <= cfg_data;
                pidc_pkg::REG_OUTPUT_MIN:   output_min_reg   <= cfg_data[DRIVE_W-1:0];
                pidc_pkg::REG_OUTPUT_MAX:   output_max_reg   <= cfg_data[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // Error and derivative
    assign err_calc   = ERR_W'(target_angle_reg) - ERR_W'(meas_angle);
    assign diff       = DIFF_W'(err_reg) - DIFF_W'(last_error_reg);
    assign diff_ext   = DERIV_W'(diff);
    // times 25 as 16 + 8 + 1
    assign deriv_calc = (diff_ext <<< 4) + (diff_ext <<< 3) + diff_ext;

    // Shared multiplier operands
    assign integ_ext = EXT_W'(integ_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            pidc_pkg::MUL_ERR_DT:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(pidc_pkg::DT_Q16);
            end
            pidc_pkg::MUL_PROP:
            begin
                mul_a = MUL_A_W'(prop_gain_reg);
                mul_b = MUL_B_W'(err_reg);
            end
            pidc_pkg::MUL_DERIV:
            begin
                mul_a = MUL_A_W'(deriv_gain_reg);
                mul_b = MUL_B_W'(deriv_reg);
            end
            pidc_pkg::MUL_INT_LO:
            begin
                mul_a = MUL_A_W'(integ_gain_reg);
                mul_b = signed'({1'b0, integ_ext[HALF_W-1:0]});
            end
            pidc_pkg::MUL_INT_HI:
            begin
                mul_a = MUL_A_W'(integ_gain_reg);
                mul_b = MUL_B_W'(signed'(integ_ext[EXT_W-1:HALF_W]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Saturating integral update
    assign inc  = prod_reg[INC_W-1:0];
    assign isum = ISUM_W'(integ_reg) + ISUM_W'(inc);

    always_comb
    begin
        if (isum > IMAX)
        begin
            integ_next = IMAX[INTEGRAL_WIDTH-1:0];
        end
        else if (isum < IMIN)
        begin
            integ_next = IMIN[INTEGRAL_WIDTH-1:0];
        end
        else
        begin
            integ_next = isum[INTEGRAL_WIDTH-1:0];
        end
    end

    // Integral term saturates at magnitude 2^60, keeping its sign
    always_comb
    begin
        if (iacc_reg > LIM_POS)
        begin
            isat = LIM_POS[ISAT_W-1:0];
        end
        else if (iacc_reg < LIM_NEG)
        begin
            isat = LIM_NEG[ISAT_W-1:0];
        end
        else
        begin
            isat = iacc_reg[ISAT_W-1:0];
        end
    end

    // Half away from zero: for a negative sum, -s + half = ~s + half + 1
    assign rnd_sum = (sum_reg[ACC_W-1] ? ~sum_reg : sum_reg)
                   + (sum_reg[ACC_W-1] ? (HALF_LSB + ACC_W'(1)) : HALF_LSB);

    // Clamp: compare with the upper limit first; a negative value is below both
    always_comb
    begin
        if (neg_reg && (rnd_reg != '0))
        begin
            drive_calc = output_min_reg;
        end
        else if (rnd_reg > RND_W'(output_max_reg))
        begin
            drive_calc = output_max_reg;
        end
        else if (rnd_reg < RND_W'(output_min_reg))
        begin
            drive_calc = output_min_reg;
        end
        else
        begin
            drive_calc = rnd_reg[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg      <= '0;
            last_error_reg <= '0;
        end
        else if (cmd.clear)
        begin
            integ_reg      <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            if (cmd.int_upd)
            begin
                integ_reg <= integ_next;
            end
            if (cmd.deriv_upd)
            begin
                last_error_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full;
        if (cmd.load_err)
        begin
            err_reg <= err_calc;
        end
        if (cmd.deriv_upd)
        begin
            deriv_reg <= deriv_calc;
        end
        if (cmd.p_load)
        begin
            acc_reg <= ACC_W'(prod_reg) <<< pidc_pkg::GAIN_SHIFT;
        end
        if (cmd.d_add)
        begin
            acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< pidc_pkg::GAIN_SHIFT);
        end
        if (cmd.ilo_load)
        begin
            iacc_reg <= IACC_W'(prod_reg);
        end
        if (cmd.ihi_add)
        begin
            iacc_reg <= iacc_reg + (IACC_W'(prod_reg) <<< pidc_pkg::HALF_SHIFT);
        end
        if (cmd.sum_load)
        begin
            sum_reg <= acc_reg + ACC_W'(isat);
        end
        if (cmd.round_load)
        begin
            rnd_reg <= rnd_sum[ACC_W-1:pidc_pkg::ROUND_SHIFT];
            neg_reg <= sum_reg[ACC_W-1];
        end
        if (cmd.out_load)
        begin
            drive_reg <= drive_calc;
        end
    end

    assign drive = drive_reg;

endmodule

// ----- rtl/pid_controller_clamped.sv -----
// Top level of the clamped positional PID controller.
`timescale 1ns / 1ps
// A sample beat steps through MUL_INC, MUL_P, MUL_D, MUL_ILO, MUL_IHI, I_ADD, SUM, ROUND
// and CLAMP, which registers its drive beat once no earlier result waits. No new sample
// is taken before then; a single shared 17x33 multiplier forms the integral increment,
// the P and D products and both halves of the I product. A clear beat gives no output beat.
// Reset (rst_n, asynchronous, active low) clears integral and previous error, sets the
// gains and setpoint to zero and the drive limits to 0 and 180; no clearing pass.
module pid_controller_clamped #(
    parameter int INTEGRAL_WIDTH = pidc_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Settings write port: index follows the register list (prop_gain first)
    input  logic                                cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Sample stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [15:0] measured_angle
    input  logic [0:0]                          s_axis_tuser,  // [0] command

    // Drive stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata   // [7:0] drive
);

    pidc_pkg::dp_cmd_t dp_cmd;

    // Sequencer: takes one beat at a time, holds the result beat until it is taken,
    // and stalls the final step while an earlier result still waits.
    pidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (dp_cmd)
    );

    // Datapath: error, saturating integral, derivative, shared multiplier,
    // Q.30 sum, rounding and clamp into the output register.
    pidc_datapath #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .meas_angle (signed'(s_axis_tdata)),
        .cmd        (dp_cmd),
        .drive      (m_axis_tdata)
    );

endmodule
